/* sv/duplicate_value_finder_defines.svh */
// assertion macros for the duplicate value finder
`ifndef DUPLICATE_VALUE_FINDER_DEFINES_SVH
`define DUPLICATE_VALUE_FINDER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define DVF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define DVF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dvf_pkg.sv */
// shared types and constants for the duplicate value finder
`default_nettype none

package dvf_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] dup_value;
    logic                      none_found;
    logic                      overflow;
    logic                      last_result;
  } result_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_ISSUE_I,
    S_LATCH_V,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

/* sv/duplicate_value_finder.sv */
// top level of the duplicate value finder: element store and search sequencer
// usage:
//   a transaction on the input side is taken at a rising edge with start high
//   and busy low; item carries one signed value and the last_item mark.
//   while loading, busy stays low and one element is taken every cycle.
//   the element with last_item set closes the set and raises busy for the search.
//   elements past DEPTH are dropped and every result of that run has overflow set.
//   results come out on result, each valid for exactly one cycle with strobe high;
//   the receiver cannot stall, so each result is taken in the cycle it is shown.
//   duplicates are reported once each, in order of first occurrence, the final one
//   marked last_result; a set with no repeated value gives one none_found result.
// search:
//   the search walks the n stored elements through the single read port of the
//   element store: per element the setup states S_ISSUE_I and S_LATCH_V, then
//   S_SCAN compares until a copy or the last stored element is found; S_FINISH
//   closes the run (n at most DEPTH).
// reset:
//   rst is synchronous and active high; it empties the set, clears the overflow
//   flag and any pending result.  the store needs no clearing pass, entries are
//   only read below the element count.
`default_nettype none
`include "duplicate_value_finder_defines.svh"

module duplicate_value_finder (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire dvf_pkg::item_t  item,
  output logic                 strobe,
  output dvf_pkg::result_t     result
);

  // element store, one write port for loading, one registered read port
  logic signed [dvf_pkg::VALUE_W-1:0] mem [dvf_pkg::DEPTH];
  logic signed [dvf_pkg::VALUE_W-1:0] rdata;
  logic [dvf_pkg::ADDR_W-1:0]         rd_addr;
  logic                               mem_we;

  dvf_pkg::state_t state, state_next;

  logic [dvf_pkg::CNT_W-1:0]          count, count_next;
  logic                               overflow_seen, overflow_seen_next;
  logic [dvf_pkg::ADDR_W-1:0]         i_idx, i_idx_next;     // element under test
  logic [dvf_pkg::CNT_W-1:0]          t_cnt, t_cnt_next;     // next scan read
  logic                               cmp_valid, cmp_valid_next;
  logic [dvf_pkg::ADDR_W-1:0]         cmp_idx, cmp_idx_next; // index of rdata
  logic signed [dvf_pkg::VALUE_W-1:0] v_reg, v_reg_next;
  logic                               pend_valid, pend_valid_next;
  logic signed [dvf_pkg::VALUE_W-1:0] pend_value, pend_value_next;
  logic                               strobe_next;
  dvf_pkg::result_t                   result_next;

  logic accept;
  logic hit;       // another copy of v found in the scan
  logic dup;       // copy lies after v: v is a first occurrence with a repeat
  logic scan_end;  // compare of the last stored element
  logic decide;    // scan of this element is over
  logic last_i;    // element under test is the last stored one

  assign busy     = (state != dvf_pkg::S_LOAD);
  assign accept   = start && !busy;
  assign hit      = cmp_valid && (rdata == v_reg) && (cmp_idx != i_idx);
  assign dup      = hit && (cmp_idx > i_idx);
  assign scan_end = cmp_valid &&
                    ((dvf_pkg::CNT_W'(cmp_idx) + dvf_pkg::CNT_W'(1)) == count);
  assign decide   = hit || scan_end;
  assign last_i   = (dvf_pkg::CNT_W'(i_idx) + dvf_pkg::CNT_W'(1)) == count;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[dvf_pkg::ADDR_W-1:0]] <= item.value;
    end
    rdata <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dvf_pkg::S_LOAD: begin
        if (accept && item.last_item) begin
          state_next = dvf_pkg::S_ISSUE_I;
        end
      end
      dvf_pkg::S_ISSUE_I: state_next = dvf_pkg::S_LATCH_V;
      dvf_pkg::S_LATCH_V: state_next = dvf_pkg::S_SCAN;
      dvf_pkg::S_SCAN: begin
        if (decide) begin
          state_next = last_i ? dvf_pkg::S_FINISH : dvf_pkg::S_ISSUE_I;
        end
      end
      dvf_pkg::S_FINISH: state_next = dvf_pkg::S_LOAD;
      default: state_next = dvf_pkg::S_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_next         = count;
    overflow_seen_next = overflow_seen;
    i_idx_next         = i_idx;
    t_cnt_next         = t_cnt;
    cmp_valid_next     = cmp_valid;
    cmp_idx_next       = cmp_idx;
    v_reg_next         = v_reg;
    pend_valid_next    = pend_valid;
    pend_value_next    = pend_value;
    strobe_next        = 1'b0;
    result_next        = result;
    rd_addr            = t_cnt[dvf_pkg::ADDR_W-1:0];
    mem_we             = 1'b0;
    case (state)
      dvf_pkg::S_LOAD: begin
        i_idx_next     = '0;
        cmp_valid_next = 1'b0;
        if (accept) begin
          if (count < dvf_pkg::CNT_W'(dvf_pkg::DEPTH)) begin
            mem_we     = 1'b1;
            count_next = count + dvf_pkg::CNT_W'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
        end
      end
      dvf_pkg::S_ISSUE_I: begin
        rd_addr        = i_idx;
        t_cnt_next     = '0;
        cmp_valid_next = 1'b0;
      end
      dvf_pkg::S_LATCH_V: begin
        // value of element i arrives, first scan read goes out
        v_reg_next     = rdata;
        t_cnt_next     = t_cnt + dvf_pkg::CNT_W'(1);
        cmp_valid_next = 1'b1;
        cmp_idx_next   = t_cnt[dvf_pkg::ADDR_W-1:0];
      end
      dvf_pkg::S_SCAN: begin
        if (dup) begin
          // hold the newest duplicate so the final one can be marked last
          if (pend_valid) begin
            strobe_next = 1'b1;
            result_next = '{dup_value: pend_value, none_found: 1'b0,
                            overflow: overflow_seen, last_result: 1'b0};
          end
          pend_valid_next = 1'b1;
          pend_value_next = v_reg;
        end
        if (decide) begin
          cmp_valid_next = 1'b0;
          if (!last_i) begin
            i_idx_next = i_idx + dvf_pkg::ADDR_W'(1);
          end
        end else if (t_cnt < count) begin
          t_cnt_next     = t_cnt + dvf_pkg::CNT_W'(1);
          cmp_valid_next = 1'b1;
          cmp_idx_next   = t_cnt[dvf_pkg::ADDR_W-1:0];
        end else begin
          cmp_valid_next = 1'b0;
        end
      end
      dvf_pkg::S_FINISH: begin
        strobe_next = 1'b1;
        if (pend_valid) begin
          result_next = '{dup_value: pend_value, none_found: 1'b0,
                          overflow: overflow_seen, last_result: 1'b1};
        end else begin
          result_next = '{dup_value: '0, none_found: 1'b1,
                          overflow: overflow_seen, last_result: 1'b1};
        end
        count_next         = '0;
        overflow_seen_next = 1'b0;
        pend_valid_next    = 1'b0;
      end
      default: begin
        cmp_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dvf_pkg::S_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
      cmp_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      strobe        <= 1'b0;
      i_idx         <= '0;
      t_cnt         <= '0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      overflow_seen <= overflow_seen_next;
      cmp_valid     <= cmp_valid_next;
      pend_valid    <= pend_valid_next;
      strobe        <= strobe_next;
      i_idx         <= i_idx_next;
      t_cnt         <= t_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx    <= cmp_idx_next;
    v_reg      <= v_reg_next;
    pend_value <= pend_value_next;
    result     <= result_next;
  end

  // the closing result always lands back in the load state
  `DVF_ASSERT_NOW(a_last_ends_run, strobe && result.last_result, state == dvf_pkg::S_LOAD, "last result outside load state")
  // an intermediate duplicate is reported while the search still runs
  `DVF_ASSERT_NOW(a_mid_busy, strobe && !result.last_result, busy, "intermediate result while idle")
  // a none_found report is the only result of its run
  `DVF_ASSERT_NOW(a_none_is_last, strobe && result.none_found, result.last_result, "none_found result not last")
  // closing element starts the search
  `DVF_ASSERT_NEXT(a_last_starts_search, accept && item.last_item, state == dvf_pkg::S_ISSUE_I, "search not started")
  // compare pipeline only carries data while scanning
  `DVF_ASSERT_NOW(a_cmp_in_scan, cmp_valid, state == dvf_pkg::S_SCAN, "compare valid outside scan")

endmodule

`default_nettype wire
